>>> hw/rtl/gttg_pkg.sv
`timescale 1ns / 1ps
// Gamepad turbo toggle gate: shared types, codes and defaults.
// No dependencies.
package gttg_pkg;

    localparam int NUM_BUTTONS_DEF = 32;
    localparam int TIME_BITS_DEF   = 32;
    localparam int CFG_W           = 32;
    localparam int FIELD_W         = 32;
    localparam int ADDR_W          = 4;
    localparam int MOD_IDX_W       = 5;

    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_RENDER = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_NOP    = 2'd3;

    localparam logic [1:0] REG_ENABLED     = 2'd0;
    localparam logic [1:0] REG_MOD_INDEX   = 2'd1;
    localparam logic [1:0] REG_TARGET_MASK = 2'd2;
    localparam logic [1:0] REG_HALF_PERIOD = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic done;
        logic odd;
    } div_res_t;

endpackage

>>> hw/rtl/gttg_div.sv
`timescale 1ns / 1ps
// Serial restoring divider, one quotient bit per cycle; reports quotient parity.
// Depends on gttg_pkg.
module gttg_div #(
    parameter int DVD_W = gttg_pkg::TIME_BITS_DEF,
    parameter int DSR_W = gttg_pkg::CFG_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DVD_W-1:0]   dividend,
    input  logic [DSR_W-1:0]   divisor,
    output gttg_pkg::div_res_t res
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic             odd_reg, odd_next;
    logic [DSR_W:0]   rem_sh;
    logic [DSR_W:0]   diff;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[DVD_W-1]};
        ge        = rem_sh >= {1'b0, dsr_reg};
        diff      = rem_sh - {1'b0, dsr_reg};
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        odd_next  = odd_reg;
        if (start)
        begin
            dvd_next = dividend;
            dsr_next = divisor;
            rem_next = '0;
            cnt_next = CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                done_next = 1'b1;
                odd_next  = ge;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        odd_reg <= odd_next;
    end

    assign res.done = done_reg;
    assign res.odd  = odd_reg;

endmodule

>>> hw/rtl/gamepad_turbo_toggle_gate_core.sv
`timescale 1ns / 1ps
// Update sweeps all buttons, storing a hold time for each newly held turbo button;
// render scans all buttons and runs the serial divider for each held turbo button;
// clear and no-op go straight to the result. One transaction at a time.
// The output register lets the next transaction enter while a result waits.
// Reset (rst_n, async low) clears marks, config to defaults; hold times need none.
module gamepad_turbo_toggle_gate_core #(
    parameter int NUM_BUTTONS = gttg_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = gttg_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gttg_pkg::ADDR_W-1:0]      paddr,
    input  logic [gttg_pkg::CFG_W-1:0]       pwdata,
    output logic [gttg_pkg::CFG_W-1:0]       prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       req_type,
    input  logic [gttg_pkg::FIELD_W-1:0]     buttons,
    input  logic [gttg_pkg::FIELD_W-1:0]     now,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [gttg_pkg::FIELD_W-1:0]     buttons_out,
    output logic [gttg_pkg::FIELD_W-1:0]     changed_mask,
    output logic [gttg_pkg::FIELD_W-1:0]     active_mask,
    output logic                             ticking
);

    localparam int NB    = NUM_BUTTONS;
    localparam int IDX_W = (NB > 1) ? $clog2(NB) : 1;
    localparam int NOW_W = (TIME_BITS < gttg_pkg::FIELD_W) ? TIME_BITS : gttg_pkg::FIELD_W;
    localparam int CW    = gttg_pkg::CFG_W;
    localparam int FW    = gttg_pkg::FIELD_W;

    // configuration
    logic                          enabled_reg;
    logic [gttg_pkg::MOD_IDX_W-1:0] mod_idx_reg;
    logic [CW-1:0]                 target_reg;
    logic [CW-1:0]                 half_reg;
    logic                          cfg_wr;

    // sequencer and state
    gttg_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [NB-1:0]    active_reg, active_next;
    logic [NB-1:0]    supp_reg, supp_next;
    logic [NB-1:0]    prev_reg, prev_next;
    logic [NB-1:0]    held_reg, held_next;
    logic [NB-1:0]    sv_reg, sv_next;
    logic [NB-1:0]    fresh_reg, fresh_next;
    logic [NOW_W-1:0] now_reg, now_next;
    logic [NB-1:0]    res_buttons_reg, res_buttons_next;
    logic [NB-1:0]    res_changed_reg, res_changed_next;
    logic             out_valid_reg, out_valid_next;
    logic [FW-1:0]    out_buttons_reg, out_buttons_next;
    logic [FW-1:0]    out_changed_reg, out_changed_next;
    logic [FW-1:0]    out_active_reg, out_active_next;
    logic             out_ticking_reg, out_ticking_next;

    // update datapath
    logic [NB-1:0] raw, mod_mask, toggle, upd_active, upd_supp, upd_changed;
    logic [NB-1:0] upd_filtered, upd_hold;
    logic [NB-1:0] live;
    logic          last_idx;
    logic          in_acc;

    // hold-time memory and divider
    logic [NOW_W-1:0]     since_mem [NB];
    logic [NOW_W-1:0]     rd_data_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic                 div_start;
    logic [TIME_BITS-1:0] elapsed;
    logic [CW-1:0]        half_eff;
    gttg_pkg::div_res_t   div_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            mod_idx_reg <= '0;
            target_reg  <= '1;
            half_reg    <= CW'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                gttg_pkg::REG_ENABLED:     enabled_reg <= pwdata[0];
                gttg_pkg::REG_MOD_INDEX:   mod_idx_reg <= pwdata[gttg_pkg::MOD_IDX_W-1:0];
                gttg_pkg::REG_TARGET_MASK: target_reg  <= pwdata;
                gttg_pkg::REG_HALF_PERIOD: half_reg    <= pwdata;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            gttg_pkg::REG_ENABLED:     prdata = CW'(enabled_reg);
            gttg_pkg::REG_MOD_INDEX:   prdata = CW'(mod_idx_reg);
            gttg_pkg::REG_TARGET_MASK: prdata = target_reg;
            gttg_pkg::REG_HALF_PERIOD: prdata = half_reg;
            default:                   prdata = '0;
        endcase
    end

    // update step; modifier index beyond the pad shifts out to no modifier
    always_comb
    begin
        raw         = NB'(buttons);
        mod_mask    = NB'(1) << mod_idx_reg;
        toggle      = raw & ~prev_reg & ~mod_mask & NB'(target_reg);
        upd_active  = active_reg;
        upd_supp    = supp_reg;
        upd_changed = '0;
        if (!enabled_reg)
        begin
            upd_changed = active_reg;
            upd_active  = '0;
        end
        else if ((raw & mod_mask) != '0)
        begin
            upd_active  = active_reg ^ toggle;
            upd_supp    = supp_reg | toggle;
            upd_changed = toggle;
        end
        upd_supp     = upd_supp & raw;
        upd_filtered = raw & ~upd_supp;
        upd_hold     = upd_active & upd_filtered;
    end

    assign live     = sv_reg & active_reg & held_reg;
    assign last_idx = (idx_reg == IDX_W'(NB - 1));
    assign in_ready = (state_reg == gttg_pkg::ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign elapsed  = TIME_BITS'(now_reg) - TIME_BITS'(rd_data_reg);
    assign half_eff = (half_reg == '0) ? CW'(1) : half_reg;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        active_next      = active_reg;
        supp_next        = supp_reg;
        prev_next        = prev_reg;
        held_next        = held_reg;
        sv_next          = sv_reg;
        fresh_next       = fresh_reg;
        now_next         = now_reg;
        res_buttons_next = res_buttons_reg;
        res_changed_next = res_changed_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_buttons_next = out_buttons_reg;
        out_changed_next = out_changed_reg;
        out_active_next  = out_active_reg;
        out_ticking_next = out_ticking_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        div_start        = 1'b0;

        unique case (state_reg)
            gttg_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next = '0;
                    now_next = NOW_W'(now);
                    case (req_type)
                        gttg_pkg::REQ_UPDATE:
                        begin
                            active_next      = upd_active;
                            supp_next        = upd_supp;
                            prev_next        = raw;
                            held_next        = upd_filtered;
                            sv_next          = upd_hold;
                            fresh_next       = upd_hold & ~sv_reg;
                            res_buttons_next = upd_filtered;
                            res_changed_next = upd_changed;
                            state_next       = gttg_pkg::ST_SWEEP;
                        end
                        gttg_pkg::REQ_RENDER:
                        begin
                            res_buttons_next = held_reg;
                            res_changed_next = '0;
                            state_next       = gttg_pkg::ST_SCAN;
                        end
                        gttg_pkg::REQ_CLEAR:
                        begin
                            res_buttons_next = '0;
                            res_changed_next = active_reg;
                            active_next      = '0;
                            sv_next          = '0;
                            state_next       = gttg_pkg::ST_EMIT;
                        end
                        default:
                        begin
                            res_buttons_next = '0;
                            res_changed_next = '0;
                            state_next       = gttg_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            gttg_pkg::ST_SWEEP:
            begin
                mem_we = fresh_reg[idx_reg];
                if (last_idx)
                    state_next = gttg_pkg::ST_EMIT;
                else
                    idx_next = idx_reg + 1'b1;
            end
            gttg_pkg::ST_SCAN:
            begin
                if (live[idx_reg])
                begin
                    mem_re     = 1'b1;
                    state_next = gttg_pkg::ST_LOAD;
                end
                else if (last_idx)
                    state_next = gttg_pkg::ST_EMIT;
                else
                    idx_next = idx_reg + 1'b1;
            end
            gttg_pkg::ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = gttg_pkg::ST_DIV;
            end
            gttg_pkg::ST_DIV:
            begin
                if (div_res.done)
                begin
                    if (div_res.odd)
                        res_buttons_next[idx_reg] = 1'b0;
                    if (last_idx)
                        state_next = gttg_pkg::ST_EMIT;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = gttg_pkg::ST_SCAN;
                    end
                end
            end
            gttg_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_buttons_next = FW'(res_buttons_reg);
                    out_changed_next = FW'(res_changed_reg);
                    out_active_next  = FW'(active_reg);
                    out_ticking_next = |(active_reg & held_reg);
                    state_next       = gttg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gttg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gttg_pkg::ST_IDLE;
            idx_reg       <= '0;
            active_reg    <= '0;
            supp_reg      <= '0;
            prev_reg      <= '0;
            held_reg      <= '0;
            sv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            active_reg    <= active_next;
            supp_reg      <= supp_next;
            prev_reg      <= prev_next;
            held_reg      <= held_next;
            sv_reg        <= sv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fresh_reg       <= fresh_next;
        now_reg         <= now_next;
        res_buttons_reg <= res_buttons_next;
        res_changed_reg <= res_changed_next;
        out_buttons_reg <= out_buttons_next;
        out_changed_reg <= out_changed_next;
        out_active_reg  <= out_active_next;
        out_ticking_reg <= out_ticking_next;
    end

    // hold start times, one entry per button
    always_ff @(posedge clk)
    begin
        if (mem_we)
            since_mem[idx_reg] <= now_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rd_data_reg <= since_mem[idx_reg];
    end

    gttg_div #(
        .DVD_W (TIME_BITS),
        .DSR_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed),
        .divisor  (half_eff),
        .res      (div_res)
    );

    assign out_valid    = out_valid_reg;
    assign buttons_out  = out_buttons_reg;
    assign changed_mask = out_changed_reg;
    assign active_mask  = out_active_reg;
    assign ticking      = out_ticking_reg;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == gttg_pkg::ST_DIV))
        else $error("divider finished outside its wait state");

    a_since_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (sv_reg & ~(active_reg & held_reg)) == '0)
        else $error("hold time valid for a button that is not a held turbo button");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gttg_pkg::ST_EMIT) |-> ((res_buttons_reg & ~held_reg) == '0))
        else $error("result shows a button that is not held");
`endif

endmodule
